[design/lfrx_pkg.sv]
// ----------------------------------------------------------------------------
// lfrx_pkg
// Shared types, reset values and the CRC-16 byte fold of the frame receiver.
// ----------------------------------------------------------------------------
package lfrx_pkg;

    localparam int HDR_BYTES = 3;
    localparam int CRC_BYTES = 2;
    localparam int BYTE_BITS = 8;

    localparam logic [15:0] TIMEOUT_RST = 16'd2;
    localparam logic [15:0] POLY_RST    = 16'hA001;
    localparam logic [15:0] START_RST   = 16'hFFFF;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_POLY    = 2'd1;
    localparam logic [1:0] REG_START   = 2'd2;

    typedef struct packed {
        logic [15:0] timeout;
        logic [15:0] poly;
        logic [15:0] start;
    } t_cfg;

    // one completed frame handed from the front to the back
    typedef struct packed {
        logic        status;
        logic [7:0]  address;
        logic [7:0]  command;
        logic [7:0]  payload_len;
        logic [15:0] received_crc;
        logic [15:0] crc_fail_count;
        logic [7:0]  n_out;
        logic        bank;
    } t_job;

    typedef struct packed {
        logic clr;
        logic bank;
    } t_back_stat;

    typedef struct packed {
        logic        status;
        logic [7:0]  address;
        logic [7:0]  command;
        logic [7:0]  payload_len;
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic [7:0]  byte_index;
        logic [15:0] received_crc;
        logic [15:0] crc_fail_count;
        logic        last;
    } t_result;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < BYTE_BITS; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[design/lfrx_if.sv]
// ----------------------------------------------------------------------------
// lfrx_if
// Valid/ready channels of the frame receiver: input items and result items.
// ----------------------------------------------------------------------------
interface lfrx_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface lfrx_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [7:0]  address;
    logic [7:0]  command;
    logic [7:0]  payload_len;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic [7:0]  byte_index;
    logic [15:0] received_crc;
    logic [15:0] crc_fail_count;
    logic        last;

    modport source (output valid, output status, output address, output command,
                    output payload_len, output payload_byte, output byte_valid,
                    output byte_index, output received_crc, output crc_fail_count,
                    output last, input ready);
    modport sink (input valid, input status, input address, input command,
                  input payload_len, input payload_byte, input byte_valid,
                  input byte_index, input received_crc, input crc_fail_count,
                  input last, output ready);
endinterface

[design/lfrx_front.sv]
// ----------------------------------------------------------------------------
// lfrx_front
// Takes bytes and ticks, tracks framing, CRC and timeout, writes the payload
// store and queues one job per completed frame.
// ----------------------------------------------------------------------------
module lfrx_front
    import lfrx_pkg::*;
#(
    parameter int MAX_FRAME     = 64,
    parameter int PAYLOAD_STORE = 59,
    localparam int AW = $clog2(MAX_FRAME),
    localparam int CW = $clog2(MAX_FRAME + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    lfrx_in_if.sink       i_in,
    output logic          o_wr_en,
    output logic [AW:0]   o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_push,
    output t_job          o_job,
    input  logic          i_fifo_full,
    input  t_back_stat    i_back
);

    logic [CW-1:0] r_cnt, n_cnt;
    logic [8:0]    r_fl, n_fl;
    logic [15:0]   r_crc, n_crc;
    logic [15:0]   r_fail, n_fail;
    logic [15:0]   r_ticks, n_ticks;
    logic [1:0]    r_busy, n_busy;
    logic          r_bank, n_bank;
    logic [7:0]    r_addr, n_addr;
    logic [7:0]    r_cmd, n_cmd;
    logic [7:0]    r_len, n_len;
    logic [7:0]    r_prev, n_prev;

    logic          w_fire;
    logic [15:0]   w_limit;
    logic [15:0]   w_ticks_inc;
    logic [15:0]   w_crc_base;
    logic [CW-1:0] w_cnt_nx;
    logic [8:0]    w_fl_new;
    logic [15:0]   w_rcrc;
    logic [7:0]    w_n;

    assign i_in.ready = !i_fifo_full && !r_busy[r_bank];
    assign w_fire     = i_in.valid && i_in.ready;

    assign w_limit     = (i_cfg.timeout == 16'd0) ? 16'd1 : i_cfg.timeout;
    assign w_ticks_inc = r_ticks + 16'd1;
    assign w_crc_base  = (r_cnt == CW'(0)) ? i_cfg.start : r_crc;
    assign w_cnt_nx    = r_cnt + CW'(1);
    assign w_fl_new    = 9'(HDR_BYTES + CRC_BYTES) + {1'b0, i_in.rx_byte};
    assign w_rcrc      = {i_in.rx_byte, r_prev};
    assign w_n         = (r_len < 8'(PAYLOAD_STORE)) ? r_len : 8'(PAYLOAD_STORE);

    always_comb begin
        n_cnt   = r_cnt;
        n_fl    = r_fl;
        n_crc   = r_crc;
        n_fail  = r_fail;
        n_ticks = r_ticks;
        n_busy  = r_busy;
        n_bank  = r_bank;
        n_addr  = r_addr;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_prev  = r_prev;
        o_wr_en   = 1'b0;
        o_wr_addr = {r_bank, r_cnt[AW-1:0]};
        o_wr_data = i_in.rx_byte;
        o_push    = 1'b0;
        o_job     = '0;

        if (i_back.clr) begin
            n_busy[i_back.bank] = 1'b0;
        end

        if (w_fire) begin
            if (i_in.mode) begin
                if (w_ticks_inc >= w_limit) begin
                    n_ticks = 16'd0;
                    n_cnt   = '0;
                    n_fl    = 9'd0;
                    n_crc   = i_cfg.start;
                end else begin
                    n_ticks = w_ticks_inc;
                end
            end else begin
                n_ticks = 16'd0;
                if (r_cnt >= CW'(MAX_FRAME)) begin
                    // store overflow, byte dropped
                    n_cnt = '0;
                    n_fl  = 9'd0;
                    n_crc = i_cfg.start;
                end else begin
                    o_wr_en = 1'b1;
                    n_cnt   = w_cnt_nx;
                    n_prev  = i_in.rx_byte;
                    if (r_cnt == CW'(0)) begin
                        n_addr = i_in.rx_byte;
                    end
                    if (r_cnt == CW'(1)) begin
                        n_cmd = i_in.rx_byte;
                    end
                    if (r_cnt == CW'(2)) begin
                        n_len = i_in.rx_byte;
                    end
                    if ((r_cnt < CW'(HDR_BYTES)) ||
                        (r_fl != 9'd0 && (9'(r_cnt) + 9'(CRC_BYTES)) < r_fl)) begin
                        n_crc = crc_fold(w_crc_base, i_in.rx_byte, i_cfg.poly);
                    end else begin
                        n_crc = w_crc_base;
                    end

                    if (w_cnt_nx == CW'(HDR_BYTES)) begin
                        if (w_fl_new > 9'(MAX_FRAME)) begin
                            // oversized frame, silently dropped
                            n_cnt = '0;
                            n_fl  = 9'd0;
                            n_crc = i_cfg.start;
                        end else begin
                            n_fl = w_fl_new;
                        end
                    end else if (r_fl != 9'd0 && 9'(w_cnt_nx) == r_fl) begin
                        o_push               = 1'b1;
                        o_job.address        = r_addr;
                        o_job.command        = r_cmd;
                        o_job.payload_len    = r_len;
                        o_job.received_crc   = w_rcrc;
                        o_job.bank           = r_bank;
                        if (w_rcrc != r_crc) begin
                            n_fail               = r_fail + 16'd1;
                            o_job.status         = 1'b1;
                            o_job.crc_fail_count = n_fail;
                            o_job.n_out          = 8'd0;
                        end else begin
                            o_job.status         = 1'b0;
                            o_job.crc_fail_count = r_fail;
                            o_job.n_out          = w_n;
                            if (w_n != 8'd0) begin
                                // payload bank stays locked until the back drains it
                                n_busy[r_bank] = 1'b1;
                                n_bank         = !r_bank;
                            end
                        end
                        n_cnt = '0;
                        n_fl  = 9'd0;
                        n_crc = i_cfg.start;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_fl    <= 9'd0;
            r_crc   <= START_RST;
            r_fail  <= 16'd0;
            r_ticks <= 16'd0;
            r_busy  <= 2'b00;
            r_bank  <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_fl    <= n_fl;
            r_crc   <= n_crc;
            r_fail  <= n_fail;
            r_ticks <= n_ticks;
            r_busy  <= n_busy;
            r_bank  <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_cmd  <= n_cmd;
        r_len  <= n_len;
        r_prev <= n_prev;
    end

    a_lock_free_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.n_out != 8'd0 && !o_job.status) |-> !r_busy[r_bank])
        else $error("payload job locked a bank already in use");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fl != 9'd0) |-> (r_fl >= 9'(HDR_BYTES + CRC_BYTES) && r_fl <= 9'(MAX_FRAME)))
        else $error("frame length out of range");

    a_cnt_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fl != 9'd0) |-> (9'(r_cnt) < r_fl))
        else $error("byte count ran past frame length");

endmodule

[design/lfrx_job_fifo.sv]
// ----------------------------------------------------------------------------
// lfrx_job_fifo
// Two-entry queue of completed frame jobs between front and back.
// ----------------------------------------------------------------------------
module lfrx_job_fifo
    import lfrx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_job   = r_mem[r_rptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue underflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("job queue count out of range");

endmodule

[design/lfrx_back.sv]
// ----------------------------------------------------------------------------
// lfrx_back
// Holds the two-bank payload store and turns each job into result
// transactions through a registered output stage.
// ----------------------------------------------------------------------------
module lfrx_back
    import lfrx_pkg::*;
#(
    parameter int MAX_FRAME = 64,
    localparam int AW = $clog2(MAX_FRAME)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW:0]   i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_empty,
    input  t_job          i_job,
    output logic          o_pop,
    output t_back_stat    o_stat,
    lfrx_out_if.source    o_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_LD   = 2'd2;

    logic [7:0]  r_mem [2**(AW+1)];
    logic [7:0]  r_rd_data;
    logic [AW:0] w_rd_addr;

    logic [1:0]  r_state, n_state;
    logic        r_ov, n_ov;
    t_job        r_job, n_job;
    logic [7:0]  r_idx, n_idx;
    t_result     r_res, n_res;
    logic        w_out_fire;
    logic        w_out_free;
    logic        w_last;

    assign w_rd_addr = {r_job.bank, AW'({1'b0, r_idx} + 9'(HDR_BYTES))};

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign w_out_fire = r_ov && o_out.ready;
    assign w_out_free = !r_ov || o_out.ready;
    assign w_last     = (r_idx == r_job.n_out - 8'd1);

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov && !w_out_fire;
        n_job   = r_job;
        n_idx   = r_idx;
        n_res   = r_res;
        o_pop   = 1'b0;
        o_stat  = '0;

        case (r_state)
            ST_IDLE: begin
                if (!i_empty && w_out_free) begin
                    o_pop = 1'b1;
                    if (i_job.status || i_job.n_out == 8'd0) begin
                        // error frame or empty payload: a single transaction
                        n_ov                 = 1'b1;
                        n_res.status         = i_job.status;
                        n_res.address        = i_job.address;
                        n_res.command        = i_job.command;
                        n_res.payload_len    = i_job.payload_len;
                        n_res.payload_byte   = 8'd0;
                        n_res.byte_valid     = 1'b0;
                        n_res.byte_index     = 8'd0;
                        n_res.received_crc   = i_job.received_crc;
                        n_res.crc_fail_count = i_job.crc_fail_count;
                        n_res.last           = 1'b1;
                    end else begin
                        n_job   = i_job;
                        n_idx   = 8'd0;
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_LD;
            end
            ST_LD: begin
                if (w_out_free) begin
                    n_ov                 = 1'b1;
                    n_res.status         = 1'b0;
                    n_res.address        = r_job.address;
                    n_res.command        = r_job.command;
                    n_res.payload_len    = r_job.payload_len;
                    n_res.payload_byte   = r_rd_data;
                    n_res.byte_valid     = 1'b1;
                    n_res.byte_index     = r_idx;
                    n_res.received_crc   = r_job.received_crc;
                    n_res.crc_fail_count = r_job.crc_fail_count;
                    n_res.last           = w_last;
                    if (w_last) begin
                        o_stat.clr  = 1'b1;
                        o_stat.bank = r_job.bank;
                        n_state     = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 8'd1;
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign o_out.valid          = r_ov;
    assign o_out.status         = r_res.status;
    assign o_out.address        = r_res.address;
    assign o_out.command        = r_res.command;
    assign o_out.payload_len    = r_res.payload_len;
    assign o_out.payload_byte   = r_res.payload_byte;
    assign o_out.byte_valid     = r_res.byte_valid;
    assign o_out.byte_index     = r_res.byte_index;
    assign o_out.received_crc   = r_res.received_crc;
    assign o_out.crc_fail_count = r_res.crc_fail_count;
    assign o_out.last           = r_res.last;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_idx < r_job.n_out))
        else $error("payload index beyond job length");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE))
        else $error("job taken while a run is active");

    a_release_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.clr |=> (r_ov && o_out.last && o_out.byte_valid))
        else $error("bank released without a final payload transaction");

endmodule

[design/crc16_length_framed_packet_receiver_top.sv]
// ----------------------------------------------------------------------------
// crc16_length_framed_packet_receiver_top
// Length-framed serial receiver with CRC-16 check and per-byte results.
// ----------------------------------------------------------------------------
// Input channel i_in: one transaction is a received byte (mode 0) or a
// one-millisecond tick (mode 1). Frames are address, command, length L,
// L payload bytes, CRC low, CRC high. The front takes one transaction per
// cycle while the back has a free payload bank and the job queue has room.
// Output channel o_out: a good frame gives one transaction per payload byte
// (up to PAYLOAD_STORE, or one with byte_valid 0 if empty), a CRC mismatch
// gives one transaction with status 1. A single-transaction result passes
// the job queue and the output register; a payload result passes the job
// queue, the store read and the output register, and each further payload
// result takes a new store read before it is loaded. Two payload banks and
// a two-entry job queue let the next frame arrive while the previous one
// drains; when the receiver stalls o_out, the output register holds and
// i_in.ready drops once both banks or the queue are taken. Configuration
// is an APB register port. Reset clears framing, counters and queue; the
// payload store needs no clearing pass.
// ----------------------------------------------------------------------------
module crc16_length_framed_packet_receiver_top
    import lfrx_pkg::*;
#(
    parameter int MAX_FRAME     = 64,
    parameter int PAYLOAD_STORE = 59
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lfrx_in_if.sink     i_in,
    lfrx_out_if.source  o_out
);

    localparam int AW = $clog2(MAX_FRAME);

    t_cfg        r_cfg;
    logic        w_cfg_wr;
    logic        w_wr_en;
    logic [AW:0] w_wr_addr;
    logic [7:0]  w_wr_data;
    logic        w_push;
    logic        w_pop;
    t_job        w_job_in;
    t_job        w_job_out;
    logic        w_empty;
    logic        w_full;
    t_back_stat  w_back_stat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout <= TIMEOUT_RST;
            r_cfg.poly    <= POLY_RST;
            r_cfg.start   <= START_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_TIMEOUT: r_cfg.timeout <= pwdata[15:0];
                REG_POLY:    r_cfg.poly    <= pwdata[15:0];
                REG_START:   r_cfg.start   <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TIMEOUT: prdata = {16'd0, r_cfg.timeout};
            REG_POLY:    prdata = {16'd0, r_cfg.poly};
            REG_START:   prdata = {16'd0, r_cfg.start};
            default:     prdata = 32'd0;
        endcase
    end

    lfrx_front #(
        .MAX_FRAME     (MAX_FRAME),
        .PAYLOAD_STORE (PAYLOAD_STORE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .i_fifo_full (w_full),
        .i_back      (w_back_stat)
    );

    lfrx_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    lfrx_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_empty   (w_empty),
        .i_job     (w_job_out),
        .o_pop     (w_pop),
        .o_stat    (w_back_stat),
        .o_out     (o_out)
    );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-framed CRC-16 receiver. Byte and tick
// transactions are queued, sent with random gaps and folded into a local
// frame predictor. Result transactions are taken under random stalls and
// compared field by field in order. The run steps through several register
// settings, written over APB while the receiver is idle.
// ----------------------------------------------------------------------------
module testbench;
    import lfrx_pkg::*;

    localparam int MAX_FRAME     = 64;
    localparam int PAYLOAD_STORE = 59;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 6;
    localparam int MAX_PRINTED   = 40;

    localparam logic STATUS_GOOD    = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    typedef enum logic {
        RX_BYTE = 1'b0,
        MS_TICK = 1'b1
    } t_rx_kind;

    typedef struct {
        t_rx_kind   kind;
        logic [7:0] data;
    } t_rx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lfrx_in_if  rx_chan ();
    lfrx_out_if rec_chan ();

    crc16_length_framed_packet_receiver_top #(
        .MAX_FRAME     (MAX_FRAME),
        .PAYLOAD_STORE (PAYLOAD_STORE)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (rx_chan),
        .o_out   (rec_chan)
    );

    always #10 i_clk = ~i_clk;

    // register copies seen by the frame predictor
    logic [15:0] cfg_timeout = TIMEOUT_RST;
    logic [15:0] cfg_poly    = POLY_RST;
    logic [15:0] cfg_start   = START_RST;

    // frame predictor state
    logic [7:0]  m_store [MAX_FRAME];
    int          m_count = 0;
    int          m_len   = 0;
    logic [15:0] m_crc   = START_RST;
    logic [15:0] m_fails = 16'd0;
    logic [15:0] m_idle  = 16'd0;

    t_rx_item    rx_items [$];
    t_result     expected_records [$];

    t_rx_item    cur_item;
    logic        next_valid;
    int          send_gap = 0;
    int          hold_left = 0;
    bit          no_gaps = 1'b0;

    int          error_count = 0;
    int          queued_items = 0;
    int          bytes_accepted = 0;
    int          ticks_accepted = 0;
    int          good_records = 0;
    int          crc_error_records = 0;
    int          settings_used = 1;

    function automatic logic [15:0] fold_crc_byte(logic [15:0] crc, logic [7:0] b,
                                                  logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        return c;
    endfunction

    function automatic void reset_framing();
        m_count = 0;
        m_len   = 0;
        m_crc   = cfg_start;
    endfunction

    // one accepted transaction into the predictor, results go to expected_records
    function automatic void frame_model_step(t_rx_kind kind, logic [7:0] b);
        logic [15:0] limit;
        logic [15:0] rcrc;
        int          pos;
        int          n;
        t_result     r;
        if (kind == MS_TICK) begin
            limit = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
            m_idle = m_idle + 16'd1;
            if (m_idle >= limit) begin
                m_idle = 16'd0;
                reset_framing();
            end
            return;
        end
        m_idle = 16'd0;
        if (m_count >= MAX_FRAME) begin
            reset_framing();
            return;
        end
        pos = m_count;
        if (pos == 0) begin
            m_crc = cfg_start;
        end
        m_store[pos] = b;
        m_count = pos + 1;
        // crc bytes themselves are not folded
        if (pos < HDR_BYTES || (m_len != 0 && pos + CRC_BYTES < m_len)) begin
            m_crc = fold_crc_byte(m_crc, b, cfg_poly);
        end
        if (m_count == HDR_BYTES) begin
            m_len = HDR_BYTES + int'(m_store[2]) + CRC_BYTES;
            if (m_len > MAX_FRAME) begin
                reset_framing();
                return;
            end
        end
        if (m_len == 0 || m_count != m_len) begin
            return;
        end
        rcrc = {m_store[m_len - 1], m_store[m_len - 2]};
        r.address        = m_store[0];
        r.command        = m_store[1];
        r.payload_len    = m_store[2];
        r.received_crc   = rcrc;
        r.payload_byte   = 8'h00;
        r.byte_valid     = 1'b0;
        r.byte_index     = 8'h00;
        r.last           = 1'b1;
        if (rcrc != m_crc) begin
            m_fails = m_fails + 16'd1;
            r.status         = STATUS_CRC_ERR;
            r.crc_fail_count = m_fails;
            expected_records.push_back(r);
            reset_framing();
            return;
        end
        r.status         = STATUS_GOOD;
        r.crc_fail_count = m_fails;
        n = (int'(m_store[2]) < PAYLOAD_STORE) ? int'(m_store[2]) : PAYLOAD_STORE;
        if (n == 0) begin
            expected_records.push_back(r);
        end else begin
            for (int i = 0; i < n; i++) begin
                r.payload_byte = m_store[HDR_BYTES + i];
                r.byte_valid   = 1'b1;
                r.byte_index   = 8'(i);
                r.last         = (i == n - 1);
                expected_records.push_back(r);
            end
        end
        reset_framing();
    endfunction

    task automatic report_mismatch(string msg);
        // keep the log short on a badly broken block
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("record %0d %s got %h want %h",
                                      good_records + crc_error_records, name, got, want));
        end
    endtask

    task automatic check_record();
        t_result want;
        if (expected_records.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
            return;
        end
        want = expected_records.pop_front();
        check_field("status", rec_chan.status, want.status);
        check_field("address", rec_chan.address, want.address);
        check_field("command", rec_chan.command, want.command);
        check_field("payload_len", rec_chan.payload_len, want.payload_len);
        check_field("payload_byte", rec_chan.payload_byte, want.payload_byte);
        check_field("byte_valid", rec_chan.byte_valid, want.byte_valid);
        check_field("byte_index", rec_chan.byte_index, want.byte_index);
        check_field("received_crc", rec_chan.received_crc, want.received_crc);
        check_field("crc_fail_count", rec_chan.crc_fail_count, want.crc_fail_count);
        check_field("last", rec_chan.last, want.last);
        if (want.status == STATUS_CRC_ERR) begin
            crc_error_records++;
        end else begin
            good_records++;
        end
    endtask

    // input side: one transaction at a time, random gap after each one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_chan.valid <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = rx_chan.valid;
            if (rx_chan.valid && rx_chan.ready) begin
                frame_model_step(t_rx_kind'(rx_chan.mode), rx_chan.rx_byte);
                if (rx_chan.mode == MS_TICK) begin
                    ticks_accepted++;
                end else begin
                    bytes_accepted++;
                end
                next_valid = 1'b0;
                send_gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (rx_items.size() != 0) begin
                    cur_item = rx_items.pop_front();
                    rx_chan.mode    <= cur_item.kind;
                    rx_chan.rx_byte <= cur_item.data;
                    next_valid = 1'b1;
                end
            end
            rx_chan.valid <= next_valid;
        end
    end

    // result side: random stall after each transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_chan.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (rec_chan.valid && rec_chan.ready) begin
                check_record();
                hold_left = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            rec_chan.ready <= (hold_left == 0);
        end
    end

    task automatic apb_access(logic wr, logic [1:0] idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_check(logic [1:0] idx, logic [15:0] want);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd[15:0] !== want) begin
            report_mismatch($sformatf("register %0d reads %h want %h", idx, rd[15:0], want));
        end
    endtask

    task automatic set_register(logic [1:0] idx, logic [15:0] value);
        logic [31:0] rd;
        apb_access(1'b1, idx, {16'd0, value}, rd);
        read_check(idx, value);
        case (idx)
            REG_TIMEOUT: cfg_timeout = value;
            REG_POLY:    cfg_poly    = value;
            REG_START:   cfg_start   = value;
            default: ;
        endcase
    endtask

    function automatic int tick_limit();
        return (cfg_timeout == 16'd0) ? 1 : int'(cfg_timeout);
    endfunction

    // ticks that may fall between two bytes of a frame without a restart
    function automatic int safe_gap();
        return (tick_limit() - 1 < 20) ? tick_limit() - 1 : 20;
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_rx(t_rx_kind kind, logic [7:0] data);
        t_rx_item it;
        it.kind = kind;
        it.data = data;
        rx_items.push_back(it);
        queued_items++;
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_rx(MS_TICK, rnd_byte());
    endtask

    // fill < 0 gives random payload; cut > 0 sends only that many bytes
    task automatic queue_frame(logic [7:0] addr, logic [7:0] cmd, int len, bit bad,
                               int fill, int cut, int gap_max);
        logic [7:0]  frame_bytes [$];
        logic [15:0] crc;
        int          total;
        frame_bytes = {addr, cmd, 8'(len)};
        if (len + HDR_BYTES + CRC_BYTES > MAX_FRAME) begin
            // receiver gives up right after the length byte
            foreach (frame_bytes[i]) push_rx(RX_BYTE, frame_bytes[i]);
            return;
        end
        for (int i = 0; i < len; i++) begin
            frame_bytes.push_back((fill < 0) ? rnd_byte() : 8'(fill));
        end
        crc = cfg_start;
        foreach (frame_bytes[i]) crc = fold_crc_byte(crc, frame_bytes[i], cfg_poly);
        if (bad) begin
            crc = crc ^ 16'(1 << $urandom_range(0, 15));
        end
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        total = (cut > 0) ? cut : frame_bytes.size();
        for (int i = 0; i < total; i++) begin
            if (i > 0 && gap_max > 0 && $urandom_range(0, 3) == 0) begin
                push_ticks($urandom_range(1, gap_max));
            end
            push_rx(RX_BYTE, frame_bytes[i]);
        end
    endtask

    // mostly well-formed frames; noisy phases add cut frames and garbage, each
    // followed by enough ticks to bring the receiver back to a frame start
    task automatic random_phase(int n_items, bit noisy);
        int target;
        int pick;
        int len;
        target = queued_items + n_items;
        while (queued_items < target) begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 12)
                                              : $urandom_range(13, PAYLOAD_STORE);
            if (pick < 60) begin
                queue_frame(rnd_byte(), rnd_byte(), len, $urandom_range(0, 4) == 0, -1, 0,
                            safe_gap());
            end else if (pick < 70) begin
                queue_frame(rnd_byte(), rnd_byte(), $urandom_range(PAYLOAD_STORE + 1, 255),
                            1'b0, -1, 0, 0);
            end else if (pick < 80 || !noisy) begin
                push_ticks($urandom_range(0, noisy ? tick_limit() : safe_gap()));
            end else if (pick < 90) begin
                queue_frame(rnd_byte(), rnd_byte(), len, 1'b0, -1,
                            $urandom_range(1, len + HDR_BYTES + CRC_BYTES - 1), safe_gap());
                push_ticks(tick_limit());
            end else begin
                repeat ($urandom_range(1, 4)) push_rx(RX_BYTE, rnd_byte());
                push_ticks(tick_limit());
            end
        end
        if (noisy) begin
            push_ticks(tick_limit());
        end
    endtask

    // sender holds off until every expected result is back
    task automatic wait_drained();
        while (rx_items.size() != 0 || rx_chan.valid || expected_records.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic new_setting(logic [15:0] timeout, logic [15:0] poly, logic [15:0] start);
        wait_drained();
        set_register(REG_TIMEOUT, timeout);
        set_register(REG_POLY, poly);
        set_register(REG_START, start);
        settings_used++;
    endtask

    initial begin
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 4'd0;
        pwdata  = 32'd0;
        rx_chan.valid   = 1'b0;
        rx_chan.mode    = RX_BYTE;
        rx_chan.rx_byte = 8'h00;
        rec_chan.ready  = 1'b0;
        foreach (m_store[i]) m_store[i] = 8'h00;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_check(REG_TIMEOUT, TIMEOUT_RST);
        read_check(REG_POLY, POLY_RST);
        read_check(REG_START, START_RST);

        // directed: empty payload, field extremes, bad crc, tick inside a frame,
        // partial frame timing out, oversized length
        queue_frame(8'h00, 8'hFF, 0, 1'b0, -1, 0, 0);
        queue_frame(8'hFF, 8'h00, 1, 1'b1, 8'hFF, 0, 0);
        queue_frame(8'h5A, 8'hA5, 2, 1'b0, 8'h00, 0, safe_gap());
        push_rx(RX_BYTE, 8'h11);
        push_rx(RX_BYTE, 8'h22);
        push_ticks(tick_limit());
        queue_frame(8'h01, 8'h02, PAYLOAD_STORE + 1, 1'b0, -1, 0, 0);

        // largest payload, good and bad, and the widest length byte
        queue_frame(rnd_byte(), rnd_byte(), PAYLOAD_STORE, 1'b0, -1, 0, safe_gap());
        queue_frame(rnd_byte(), rnd_byte(), PAYLOAD_STORE, 1'b1, -1, 0, 0);
        queue_frame(rnd_byte(), rnd_byte(), 255, 1'b0, -1, 0, 0);
        random_phase(10, 1'b1);

        // zero timeout acts as one tick, all-zero crc setup
        new_setting(16'd0, 16'h0000, 16'h0000);
        no_gaps = 1'b1;
        random_phase(8, 1'b1);

        // timeout that never expires here, no cut frames or garbage
        new_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
        no_gaps = 1'b0;
        random_phase(8, 1'b0);

        new_setting(16'd3, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        random_phase(8, 1'b1);

        new_setting(16'd1, 16'h8408, 16'($urandom_range(0, 65535)));
        random_phase(8, 1'b1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (expected_records.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_records.size()));
        end
        $display("sent %0d bytes and %0d ticks under %0d register settings",
                 bytes_accepted, ticks_accepted, settings_used);
        $display("checked %0d good-frame and %0d crc-error result transactions",
                 good_records, crc_error_records);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout: run did not finish, %0d results still expected",
                 expected_records.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
